// File: sv/mta_pkg.sv
// Shared types and constants for the matrix transform accumulator.
// Holds the request and response beat types, the RAM write port type,
// the CORDIC result type and the arctangent table. No dependencies.
package mta_pkg;

   localparam logic [2:0] FUNC_IDENTITY = 3'd0;
   localparam logic [2:0] FUNC_WRITE    = 3'd1;
   localparam logic [2:0] FUNC_MOVE     = 3'd2;
   localparam logic [2:0] FUNC_ROT_X    = 3'd3;
   localparam logic [2:0] FUNC_ROT_Y    = 3'd4;
   localparam logic [2:0] FUNC_ROT_Z    = 3'd5;
   // Spare codes leave the matrix untouched but still read it out.
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   localparam int ATAN_LEN = 24;
   localparam logic signed [31:0] INV_TWO_PI_Q32  = 32'sd683565276;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41721,     32'd20860,
      32'd10430,     32'd5215,      32'd2607,      32'd1303,
      32'd651,       32'd325,       32'd162,       32'd81
   };

   typedef struct packed {
      logic [2:0]         func;
      logic [3:0]         elem_index;
      logic signed [31:0] elem_value;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic signed [31:0] angle;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_index;
      logic signed [31:0] out_value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [3:0]         addr;
      logic signed [31:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin;
      logic signed [31:0] cos;
   } cordic_res_type;

endpackage

// File: sv/matrix_transform_accumulator.sv
// 4x4 affine transform accumulator in Q16.16, one command at a time.
// The next command can be accepted in the cycle of the last readout beat.
// Rotations compute sine and cosine with the CORDIC first. Each of the four rows
// is loaded into a buffer and passes through the 32x32 multiplier.
// Sixteen readout beats come one a cycle; the receiver cannot stall them.
// After reset a sweep writes the identity matrix to all 16 entries while busy is high.
module matrix_transform_accumulator #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mta_pkg::req_type req_item,
   output logic             rsp_strobe,
   output mta_pkg::rsp_type rsp_item
);

   // The sequencer walks the matrix in memory. Rows are independent under
   // post-multiplication, so each row is copied into a four-word buffer and
   // its new elements are written straight back as they complete.
   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_ANGLE = 7'b0001000,
      ST_LOAD  = 7'b0010000,
      ST_MAC   = 7'b0100000,
      ST_READ  = 7'b1000000
   } state_type;

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   state_type               state_ff, state_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [1:0]              row_ff, row_in;
   logic                    pend_ff, pend_in;
   mta_pkg::req_type        req_ff;
   logic signed [31:0]      sin_ff, cos_ff;
   logic signed [31:0]      row_buf_ff [4];
   logic signed [63:0]      prod_ff;
   logic                    pv_ff, pv_in;
   logic [1:0]              pk_ff, pc_ff;
   logic signed [65:0]      acc_ff, acc_sum, rounded;
   logic signed [31:0]      sat_val;
   logic                    rd_pend_ff, rd_pend_in;
   logic [3:0]              rd_idx_ff;
   logic [3:0]              rd_addr;
   logic signed [31:0]      rd_data;
   mta_pkg::ram_wr_type     ram_wr;
   mta_pkg::cordic_res_type cres;
   logic                    accept;

   // Elementary matrix B, entry [k][c], for the latched command.
   function automatic logic signed [31:0] b_entry(input mta_pkg::req_type r,
                                                  input logic [1:0] k,
                                                  input logic [1:0] c,
                                                  input logic signed [31:0] s,
                                                  input logic signed [31:0] co);
      logic [3:0]         idx;
      logic signed [31:0] v;
      idx = {k, c};
      v   = (k == c) ? ONE : 32'sd0;
      case (r.func)
         mta_pkg::FUNC_MOVE: begin
            if (idx == 4'd12) v = r.move_x;
            if (idx == 4'd13) v = r.move_y;
            if (idx == 4'd14) v = r.move_z;
         end
         mta_pkg::FUNC_ROT_X: begin
            if (idx == 4'd5 || idx == 4'd10) v = co;
            if (idx == 4'd6) v = -s;
            if (idx == 4'd9) v = s;
         end
         mta_pkg::FUNC_ROT_Y: begin
            if (idx == 4'd0 || idx == 4'd10) v = co;
            if (idx == 4'd2) v = -s;
            if (idx == 4'd8) v = s;
         end
         mta_pkg::FUNC_ROT_Z: begin
            if (idx == 4'd0 || idx == 4'd5) v = co;
            if (idx == 4'd1) v = -s;
            if (idx == 4'd4) v = s;
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Accumulation starts from the rounding half, so one shift finishes it.
   always_comb begin
      acc_sum = ((pk_ff == 2'd0) ? HALF : acc_ff) + 66'(prod_ff);
      rounded = acc_sum >>> FRAC_BITS;
      if (rounded > SAT_MAX) begin
         sat_val = 32'sh7fffffff;
      end else if (rounded < SAT_MIN) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val = rounded[31:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      row_in     = row_ff;
      pend_in    = pend_ff;
      pv_in      = 1'b0;
      rd_pend_in = 1'b0;
      rd_addr    = cnt_ff[3:0];
      ram_wr.en   = 1'b0;
      ram_wr.addr = cnt_ff[3:0];
      ram_wr.data = (cnt_ff[3:0] == 4'd0 || cnt_ff[3:0] == 4'd5 ||
                     cnt_ff[3:0] == 4'd10 || cnt_ff[3:0] == 4'd15) ? ONE : 32'sd0;
      case (state_ff)
         ST_INIT: begin
            ram_wr.en = 1'b1;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               cnt_in   = '0;
               state_in = pend_ff ? ST_READ : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            row_in = '0;
            if (start) begin
               case (req_item.func)
                  mta_pkg::FUNC_IDENTITY: begin
                     state_in = ST_INIT;
                     pend_in  = 1'b1;
                  end
                  mta_pkg::FUNC_WRITE: state_in = ST_WRITE;
                  mta_pkg::FUNC_MOVE:  state_in = ST_LOAD;
                  mta_pkg::FUNC_ROT_X,
                  mta_pkg::FUNC_ROT_Y,
                  mta_pkg::FUNC_ROT_Z: state_in = ST_ANGLE;
                  default:             state_in = ST_READ;
               endcase
            end
         end
         ST_WRITE: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = req_ff.elem_index;
            ram_wr.data = req_ff.elem_value;
            state_in    = ST_READ;
         end
         ST_ANGLE: begin
            if (cres.done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rd_addr = {row_ff, cnt_ff[1:0]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) begin
               cnt_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            pv_in       = !cnt_ff[4];
            ram_wr.en   = pv_ff && (pk_ff == 2'd3);
            ram_wr.addr = {row_ff, pc_ff};
            ram_wr.data = sat_val;
            cnt_in      = cnt_ff + 5'd1;
            if (cnt_ff[4]) begin
               cnt_in = '0;
               row_in = row_ff + 2'd1;
               state_in = (row_ff == 2'd3) ? ST_READ : ST_LOAD;
            end
         end
         ST_READ: begin
            rd_pend_in = 1'b1;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         cnt_ff     <= '0;
         row_ff     <= '0;
         pend_ff    <= 1'b0;
         pv_ff      <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         row_ff     <= row_in;
         pend_ff    <= pend_in;
         pv_ff      <= pv_in;
         rd_pend_ff <= rd_pend_in;
      end
      if (accept) begin
         req_ff <= req_item;
      end
      if (cres.done) begin
         sin_ff <= cres.sin;
         cos_ff <= cres.cos;
      end
      if (state_ff == ST_LOAD && cnt_ff != 5'd0) begin
         row_buf_ff[2'(cnt_ff - 5'd1)] <= rd_data;
      end
      prod_ff <= row_buf_ff[cnt_ff[1:0]] *
                 b_entry(req_ff, cnt_ff[1:0], cnt_ff[3:2], sin_ff, cos_ff);
      pk_ff   <= cnt_ff[1:0];
      pc_ff   <= cnt_ff[3:2];
      if (pv_ff) begin
         acc_ff <= acc_sum;
      end
      rd_idx_ff <= cnt_ff[3:0];
   end

   mta_matrix_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mta_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept && (req_item.func == mta_pkg::FUNC_ROT_X ||
                         req_item.func == mta_pkg::FUNC_ROT_Y ||
                         req_item.func == mta_pkg::FUNC_ROT_Z)),
      .angle (req_item.angle),
      .res   (cres)
   );

   // Response beat: registered read data with its index registered alongside it.
   assign rsp_strobe         = rd_pend_ff;
   assign rsp_item.out_index = rd_idx_ff;
   assign rsp_item.out_value = rd_data;
   assign rsp_item.last      = (rd_idx_ff == 4'd15);

   // Readout beats run in unbroken index order.
   a_readout_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |=>
         rsp_strobe && rsp_item.out_index == $past(rsp_item.out_index) + 4'd1)
      else $error("readout beats out of order");

   // The matrix is never written while it is being read out.
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !ram_wr.en)
      else $error("matrix write during readout");

   // An accepted command makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accept");

endmodule

// File: sv/mta_matrix_ram.sv
// Sixteen-entry matrix store with one write port and one registered read port.
// Depends on mta_pkg for the write port type.
module mta_matrix_ram (
   input  logic                clock,
   input  mta_pkg::ram_wr_type wr,
   input  logic [3:0]          rd_addr,
   output logic signed [31:0]  rd_data
);

   logic signed [31:0] mem [16];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mta_cordic.sv
// Angle reduction and iterative rotation-mode CORDIC giving sine and cosine.
// Depends on mta_pkg for the arctangent table and result type.
module mta_cordic #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      angle,
   output mta_pkg::cordic_res_type res
);

   localparam int NSTEPS = (CORDIC_STEPS < mta_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                              : mta_pkg::ATAN_LEN;
   localparam int DROP = 30 - FRAC_BITS;
   localparam logic signed [33:0] HALF = 34'sd1 <<< (DROP - 1);

   typedef enum logic [3:0] {
      C_IDLE  = 4'b0001,
      C_MUL   = 4'b0010,
      C_ITER  = 4'b0100,
      C_ROUND = 4'b1000
   } cstate_type;

   cstate_type         state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic signed [63:0] prod_ff;
   logic signed [33:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   logic signed [31:0] sin_ff, cos_ff, sin_in, cos_in;
   logic signed [63:0] phase_full;
   logic signed [33:0] z0, atan_val, xr, yr;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      neg_in     = neg_ff;
      done_in    = 1'b0;
      sin_in     = sin_ff;
      cos_in     = cos_ff;
      phase_full = prod_ff >>> FRAC_BITS;
      z0         = 34'(signed'(phase_full[31:0]));
      atan_val   = signed'({2'b00, mta_pkg::ATAN_TURNS[step_ff]});
      xr         = (x_ff + HALF) >>> DROP;
      yr         = (y_ff + HALF) >>> DROP;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            // Fold phases beyond a quarter turn by half a turn.
            neg_in = 1'b0;
            z_in   = z0;
            if (z0 > 34'sd1073741824) begin
               z_in   = z0 - 34'sd2147483648;
               neg_in = 1'b1;
            end else if (z0 < -34'sd1073741824) begin
               z_in   = z0 + 34'sd2147483648;
               neg_in = 1'b1;
            end
            x_in     = mta_pkg::CORDIC_GAIN_Q30;
            y_in     = '0;
            step_in  = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (!z_ff[33]) begin
               x_in = x_ff - (y_ff >>> step_ff);
               y_in = y_ff + (x_ff >>> step_ff);
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + (y_ff >>> step_ff);
               y_in = y_ff - (x_ff >>> step_ff);
               z_in = z_ff + atan_val;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(NSTEPS - 1)) begin
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            cos_in   = neg_ff ? 32'(-xr) : xr[31:0];
            sin_in   = neg_ff ? 32'(-yr) : yr[31:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      if (start) begin
         prod_ff <= angle * mta_pkg::INV_TWO_PI_Q32;
      end
   end

   assign res.done = done_ff;
   assign res.sin  = sin_ff;
   assign res.cos  = cos_ff;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the matrix transform accumulator.
// Drives command beats from a queue, predicts the 16-beat readout of each
// command and checks every response beat. Depends on mta_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int STEPS = 16;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   mta_pkg::req_type req_item = '0;
   logic rsp_strobe;
   mta_pkg::rsp_type rsp_item;

   always #2 clock = ~clock;

   matrix_transform_accumulator #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   // The predictor keeps its own copy of the matrix.
   logic signed [31:0] mat_model [16];
   mta_pkg::req_type pending_cmds [$];
   mta_pkg::rsp_type readout_beats [$];
   int error_count = 0;
   int stall_cycles = 0;

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void identity_matrix();
      for (int i = 0; i < 16; i++)
         mat_model[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
   endfunction

   // Post-multiplies the model matrix by an elementary matrix b.
   function automatic void post_multiply(input longint b [16]);
      logic signed [31:0] res [16];
      longint p, h, hi, lo;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            hi = 0;
            lo = 0;
            for (int k = 0; k < 4; k++) begin
               p = longint'(mat_model[r*4+k]) * b[k*4+c];
               h = floor_shift(p, FRAC);
               hi += h;
               lo += p - (h <<< FRAC);
            end
            lo += longint'(1) <<< (FRAC - 1);
            res[r*4+c] = clamp32(hi + floor_shift(lo, FRAC));
         end
      end
      mat_model = res;
   endfunction

   // Range reduction to a phase of a turn, then rotation-mode CORDIC.
   function automatic void sine_cosine(input longint ang, output longint s, output longint c);
      longint prod, z, x, y, nx, half;
      logic [31:0] ph;
      bit neg;
      int drop;
      drop = 30 - FRAC;
      half = longint'(1) <<< (drop - 1);
      prod = ang * 64'sd683565276;
      ph = 32'(floor_shift(prod, FRAC));
      z = longint'(signed'(ph));
      x = 64'sd652032874;
      y = 0;
      neg = 1'b0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         neg = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         neg = 1'b1;
      end
      for (int i = 0; i < STEPS && i < mta_pkg::ATAN_LEN; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= longint'(mta_pkg::ATAN_TURNS[i]);
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += longint'(mta_pkg::ATAN_TURNS[i]);
         end
         x = nx;
      end
      x = floor_shift(x + half, drop);
      y = floor_shift(y + half, drop);
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   // Applies one command to the model and queues the readout it causes.
   function automatic void predict_readout(input mta_pkg::req_type cmd);
      longint b [16];
      longint s, c;
      mta_pkg::rsp_type beat;
      for (int i = 0; i < 16; i++) b[i] = (i % 5 == 0) ? (longint'(1) <<< FRAC) : 0;
      case (cmd.func)
         mta_pkg::FUNC_IDENTITY: identity_matrix();
         mta_pkg::FUNC_WRITE: mat_model[cmd.elem_index] = cmd.elem_value;
         mta_pkg::FUNC_MOVE: begin
            b[12] = cmd.move_x;
            b[13] = cmd.move_y;
            b[14] = cmd.move_z;
            post_multiply(b);
         end
         mta_pkg::FUNC_ROT_X, mta_pkg::FUNC_ROT_Y, mta_pkg::FUNC_ROT_Z: begin
            sine_cosine(longint'(cmd.angle), s, c);
            if (cmd.func == mta_pkg::FUNC_ROT_X) begin
               b[5] = c; b[6] = -s; b[9] = s; b[10] = c;
            end else if (cmd.func == mta_pkg::FUNC_ROT_Y) begin
               b[0] = c; b[2] = -s; b[8] = s; b[10] = c;
            end else begin
               b[0] = c; b[1] = -s; b[4] = s; b[5] = c;
            end
            post_multiply(b);
         end
         default: ;
      endcase
      for (int k = 0; k < 16; k++) begin
         beat.out_index = k[3:0];
         beat.out_value = mat_model[k];
         beat.last = (k == 15);
         readout_beats.push_back(beat);
      end
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] random_q16();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
         3: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
         default: return $urandom;
      endcase
   endfunction

   function automatic mta_pkg::req_type random_cmd();
      mta_pkg::req_type cmd;
      int pick;
      cmd = '0;
      cmd.elem_index = 4'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) cmd.func = mta_pkg::FUNC_IDENTITY;
      else if (pick < 25) cmd.func = mta_pkg::FUNC_WRITE;
      else if (pick < 50) cmd.func = mta_pkg::FUNC_MOVE;
      else if (pick < 95)
         cmd.func = 3'($urandom_range(mta_pkg::FUNC_ROT_X, mta_pkg::FUNC_ROT_Z));
      else cmd.func = 3'($urandom_range(mta_pkg::FUNC_SPARE_LO, mta_pkg::FUNC_SPARE_HI));
      cmd.elem_value = random_q16();
      cmd.move_x = random_q16();
      cmd.move_y = random_q16();
      cmd.move_z = random_q16();
      cmd.angle = random_q16();
      return cmd;
   endfunction

   function automatic mta_pkg::req_type make_cmd(input logic [2:0] f, input logic [3:0] idx,
                                                 input logic signed [31:0] v);
      mta_pkg::req_type cmd;
      cmd = '0;
      cmd.func = f;
      cmd.elem_index = idx;
      cmd.elem_value = v;
      cmd.move_x = v;
      cmd.move_y = -v;
      cmd.move_z = v >>> 1;
      cmd.angle = v;
      return cmd;
   endfunction

   // Driver: one command beat per handshake, random gaps between beats.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         gap_left = gap_length();
         if (gap_left == 0 && pending_cmds.size() > 0) begin
            req_item <= pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_cmds.size() > 0) begin
            req_item <= pending_cmds.pop_front();
            start <= 1'b1;
         end
      end
   end

   // Monitor: predicts on accepted commands, checks every response beat.
   always @(posedge clock) begin
      mta_pkg::rsp_type exp_beat;
      int stall_next;
      if (!reset) begin
         stall_next = stall_cycles + 1;
         if (start && !busy) begin
            predict_readout(req_item);
            stall_next = 0;
         end
         if (rsp_strobe) begin
            stall_next = 0;
            if (readout_beats.size() == 0) begin
               report($sformatf("unexpected beat index %0d", rsp_item.out_index));
            end else begin
               exp_beat = readout_beats.pop_front();
               if (rsp_item.out_index !== exp_beat.out_index)
                  report($sformatf("index %0d, expected %0d",
                                   rsp_item.out_index, exp_beat.out_index));
               if (rsp_item.out_value !== exp_beat.out_value)
                  report($sformatf("element %0d value %h, expected %h", exp_beat.out_index,
                                   rsp_item.out_value, exp_beat.out_value));
               if (rsp_item.last !== exp_beat.last)
                  report($sformatf("element %0d last %b, expected %b", exp_beat.out_index,
                                   rsp_item.last, exp_beat.last));
            end
         end
         stall_cycles <= stall_next;
      end
   end

   // Watchdog on cycles in which nothing is accepted and no response beat arrives.
   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      identity_matrix();
      // Directed part: every operation, field extremes, unused codes.
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_SPARE_LO, 4'd0, 32'sd0));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_WRITE, 4'd0, 32'sh7fffffff));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_WRITE, 4'd15, 32'sh80000000));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_WRITE, 4'd5, 32'sh00020000));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_MOVE, 4'd0, 32'sh7fffffff));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_MOVE, 4'd0, 32'sh80000000));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_IDENTITY, 4'd15, 32'shffffffff));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_MOVE, 4'd0, 32'sh00018000));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_X, 4'd0, 32'sh0001921f));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_Y, 4'd0, 32'sh0003243f));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_Z, 4'd0, -32'sh0001921f));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_X, 4'd0, 32'sh7fffffff));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_Y, 4'd0, 32'sh80000000));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_Z, 4'd0, 32'sd0));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_ROT_Z, 4'd0, 32'sh00040000));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_SPARE_HI, 4'd9, 32'sh12345678));
      pending_cmds.push_back(make_cmd(mta_pkg::FUNC_IDENTITY, 4'd0, 32'sd0));
      for (int i = 0; i < 93; i++) pending_cmds.push_back(random_cmd());
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      while (readout_beats.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// File: files.f
sv/mta_pkg.sv
sv/mta_matrix_ram.sv
sv/mta_cordic.sv
sv/matrix_transform_accumulator.sv
tb/testbench.sv
